// ----- src/saa_pkg.sv -----
package saa_pkg;

    localparam int CAPACITY = 4096;
    localparam int OFS_W    = 13;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int SIZE_W   = 8;
    localparam int IDX_W    = 12;
    localparam int ALIGN_W  = 4;
    // Wide enough for an offset rounded up to the largest alignment plus a request.
    localparam int WIDE_W   = 17;

    localparam logic [OFS_W-1:0]  CAP_OFS  = OFS_W'(CAPACITY);
    localparam logic [SIZE_W-1:0] SIZE_MAX = 8'hFF;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_MARK  = 2'd2,
        OP_QUERY = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DECIDE,
        ST_WALK
    } t_state;

    typedef struct packed {
        t_op                op;
        logic [OFS_W-1:0]   request_size;
        logic [ALIGN_W-1:0] align_log2;
        logic [OFS_W-1:0]   block_offset;
        logic [IDX_W-1:0]   block_index;
    } t_in;

    typedef struct packed {
        logic               ok;
        logic [OFS_W-1:0]   result_offset;
        logic [SIZE_W-1:0]  result_size;
        logic [OFS_W-1:0]   block_count;
    } t_out;

    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  waddr;
        logic [SIZE_W-1:0]  wdata;
        logic [ADDR_W-1:0]  raddr;
    } t_mem_req;

endpackage

// ----- src/saa_size_store.sv -----
module saa_size_store (
    input  logic              i_clk,
    input  saa_pkg::t_mem_req i_req,
    output logic [7:0]        o_rdata
);
    import saa_pkg::*;

    logic [SIZE_W-1:0] r_mem [CAPACITY];
    logic [SIZE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/stack_arena_allocator_unit.sv -----
// Bump-pointer arena allocator over a 4096-byte heap. In iterable mode every block's
// size byte is pushed onto a stack that grows down from the top of the heap; the newest
// size byte is held in a register and the older ones live in a size store with one
// write and one read port and a registered read. Alloc, free, free to mark and a query
// of the newest block pass through a prep step, which aligns the offset and issues the
// size-store read, and a decide step, which decides and commits. A query of index n above
// zero walks the older blocks with one size-store read per block walked, and stops early
// at a size byte that does not fit. The next item is taken in the cycle that the current
// one finishes; a finished result waits in the output register, and the next item cannot
// finish until it is taken. The size store has no reset or clearing pass.
module stack_arena_allocator_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  saa_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output saa_pkg::t_out o_out_data,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic          i_cfg_data
);
    import saa_pkg::*;

    t_state r_state, n_state;
    t_in    r_in;
    logic   r_mode;

    logic [OFS_W-1:0]  r_free, n_free;
    logic [OFS_W-1:0]  r_sent, n_sent;
    logic [SIZE_W-1:0] r_top, n_top;
    logic [WIDE_W-1:0] r_start, n_start;
    logic [IDX_W-1:0]  r_k, n_k;
    logic [OFS_W-1:0]  r_pos, n_pos;
    logic [SIZE_W-1:0] r_qsize, n_qsize;
    logic              r_qok, n_qok;

    logic r_out_valid;
    t_out r_out, n_out;

    t_mem_req          mem_req;
    logic [SIZE_W-1:0] rdata;

    logic out_ok, finish, walk_done;

    saa_size_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

    // Alignment and alloc arithmetic.
    logic [WIDE_W-1:0] align_m1, start_c, end_c, gap_c, gsum_c, sent_w;
    logic              sent_full;

    assign align_m1  = (WIDE_W'(1) << r_in.align_log2) - WIDE_W'(1);
    assign start_c   = (WIDE_W'(r_free) + align_m1) & ~align_m1;
    assign end_c     = r_start + WIDE_W'(r_in.request_size);
    assign gap_c     = r_start - WIDE_W'(r_free);
    assign gsum_c    = WIDE_W'(r_top) + gap_c;
    assign sent_w    = WIDE_W'(r_sent);
    assign sent_full = (r_sent >= CAP_OFS);

    logic a_ok;
    always_comb begin
        if (!r_mode) begin
            a_ok = (end_c <= sent_w);
        end else begin
            a_ok = (r_in.request_size <= OFS_W'(SIZE_MAX)) && (end_c < sent_w)
                && (sent_full || (gsum_c <= WIDE_W'(SIZE_MAX)));
        end
    end

    // Free checks against the cached newest size byte.
    logic f_ok;
    assign f_ok = r_mode && !sent_full && (OFS_W'(r_top) <= r_free)
        && (r_in.block_offset == (r_free - OFS_W'(r_top)));

    logic m_ok;
    assign m_ok = (r_in.block_offset <= r_sent);

    // Query setup from the cached newest size byte.
    logic [OFS_W-1:0] q_count, q_pos0;
    logic             q_in_range, q_top_fit, q_walk, q_first;
    assign q_count    = CAP_OFS - r_sent;
    assign q_in_range = OFS_W'(r_in.block_index) < q_count;
    assign q_top_fit  = OFS_W'(r_top) <= r_free;
    assign q_pos0     = r_free - OFS_W'(r_top);
    assign q_first    = (r_in.block_index == '0);
    assign q_walk     = (r_in.op == OP_QUERY) && q_in_range && q_top_fit && !q_first;

    // One older size byte per cycle while walking.
    logic             w_fail, w_last;
    logic [OFS_W-1:0] w_pos_nxt, w_addr, rd_next;
    assign w_fail    = OFS_W'(rdata) > r_pos;
    assign w_last    = (r_k == r_in.block_index);
    assign w_pos_nxt = r_pos - OFS_W'(rdata);
    assign walk_done = w_fail || w_last;
    assign w_addr    = r_sent + OFS_W'(r_k) + OFS_W'(!walk_done);
    assign rd_next   = r_sent + OFS_W'(1);

    assign out_ok = !r_out_valid || i_out_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_PREP;
            end
            ST_PREP: begin
                n_state = q_walk ? ST_WALK : ST_DECIDE;
            end
            ST_DECIDE: begin
                if (out_ok) n_state = i_in_valid ? ST_PREP : ST_IDLE;
            end
            ST_WALK: begin
                if (walk_done && out_ok) n_state = i_in_valid ? ST_PREP : ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb begin
        case (r_state)
            ST_DECIDE: finish = out_ok;
            ST_WALK:   finish = walk_done && out_ok;
            default:   finish = 1'b0;
        endcase
        o_in_ready = (r_state == ST_IDLE) || finish;
    end

    // Datapath and size-store requests.
    always_comb begin
        n_free  = r_free;
        n_sent  = r_sent;
        n_top   = r_top;
        n_start = r_start;
        n_k     = r_k;
        n_pos   = r_pos;
        n_qsize = r_qsize;
        n_qok   = r_qok;

        mem_req.we    = 1'b0;
        mem_req.waddr = r_sent[ADDR_W-1:0];
        mem_req.wdata = gsum_c[SIZE_W-1:0];
        mem_req.raddr = rd_next[ADDR_W-1:0];

        n_out = '0;

        case (r_state)
            ST_PREP: begin
                n_start = start_c;
                n_qok   = q_in_range && q_top_fit && q_first;
                n_pos   = q_pos0;
                n_qsize = r_top;
                n_k     = IDX_W'(1);
            end
            ST_DECIDE: begin
                if (finish) begin
                    case (r_in.op)
                        OP_ALLOC: begin
                            if (a_ok) begin
                                n_free              = end_c[OFS_W-1:0];
                                n_out.ok            = 1'b1;
                                n_out.result_offset = r_start[OFS_W-1:0];
                                if (r_mode) begin
                                    // The cached top byte, with the gap added, moves
                                    // into the store and the new size becomes the top.
                                    mem_req.we = !sent_full;
                                    n_sent     = r_sent - OFS_W'(1);
                                    n_top      = r_in.request_size[SIZE_W-1:0];
                                end
                            end
                        end
                        OP_FREE: begin
                            if (f_ok) begin
                                n_free   = r_in.block_offset;
                                n_sent   = r_sent + OFS_W'(1);
                                n_top    = rdata;
                                n_out.ok = 1'b1;
                            end
                        end
                        OP_MARK: begin
                            if (m_ok) begin
                                n_free   = r_in.block_offset;
                                n_out.ok = 1'b1;
                            end
                        end
                        OP_QUERY: begin
                            n_out.ok            = r_qok;
                            n_out.result_offset = r_qok ? r_pos : '0;
                            n_out.result_size   = r_qok ? r_qsize : '0;
                        end
                        default: n_out = '0;
                    endcase
                end
            end
            ST_WALK: begin
                mem_req.raddr = w_addr[ADDR_W-1:0];
                if (!walk_done) begin
                    n_pos = w_pos_nxt;
                    n_k   = r_k + IDX_W'(1);
                end else if (!w_fail) begin
                    n_out.ok            = 1'b1;
                    n_out.result_offset = w_pos_nxt;
                    n_out.result_size   = rdata;
                end
            end
            default: begin
                n_out = '0;
            end
        endcase

        n_out.block_count = CAP_OFS - n_sent;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mode      <= 1'b1;
            r_free      <= '0;
            r_sent      <= CAP_OFS;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) r_mode <= i_cfg_data;
            r_free <= n_free;
            r_sent <= n_sent;
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) r_in <= i_in_data;
        if (finish) r_out <= n_out;
        r_top   <= n_top;
        r_start <= n_start;
        r_k     <= n_k;
        r_pos   <= n_pos;
        r_qsize <= n_qsize;
        r_qok   <= n_qok;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    a_sent_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sent <= CAP_OFS)
        else $error("sentinel offset above the top of the heap");

    a_free_below_sent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= r_sent)
        else $error("free offset passed the size-byte stack");

    a_write_on_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_req.we |-> (r_state == ST_DECIDE) && finish && r_mode && (r_in.op == OP_ALLOC))
        else $error("size store written outside an alloc commit");

    a_push_moves_sent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (finish && (r_state == ST_DECIDE) && (r_in.op == OP_ALLOC) && r_mode && n_out.ok)
        |=> (r_sent == $past(r_sent) - OFS_W'(1)))
        else $error("successful push did not lower the sentinel by one");

    a_walk_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_k != '0) && (r_k <= r_in.block_index))
        else $error("query walk index out of range");

endmodule

// ----- sim/arena_result_checker.sv -----
`timescale 1ns / 100ps

module arena_result_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  saa_pkg::t_in  i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  saa_pkg::t_out i_out_data,
    input  logic          i_cfg_valid,
    input  logic          i_cfg_ready,
    input  logic          i_cfg_data,
    output int            o_errors,
    output int            o_pending
);
    import saa_pkg::*;

    // Own copy of the allocator state: free offset, lowest size byte and the size stack.
    logic              iter_mode;
    int unsigned       free_ofs;
    int unsigned       stack_ofs;
    logic [SIZE_W-1:0] size_mem [CAPACITY];

    t_out pending_results [$];
    int   n_errors  = 0;
    int   n_pending = 0;

    assign o_errors  = n_errors;
    assign o_pending = n_pending;

    function automatic t_out arena_outcome(input t_in it);
        t_out        res;
        int unsigned span;
        int unsigned start;
        int unsigned stop;
        int unsigned gap;
        int unsigned sum;
        int unsigned pos;
        int unsigned k;
        bit          room;
        res = '0;
        case (it.op)
            OP_ALLOC: begin
                span  = 32'd1 << it.align_log2;
                start = (free_ofs + span - 1) & ~(span - 1);
                stop  = start + it.request_size;
                room  = 1'b0;
                if (!iter_mode) begin
                    room = (stop <= stack_ofs);
                end else if (it.request_size <= SIZE_MAX && stop < stack_ofs) begin
                    room = 1'b1;
                    gap  = start - free_ofs;
                    // The alignment gap is charged to the previous block's size byte.
                    if (gap > 0 && stack_ofs < CAPACITY) begin
                        sum = size_mem[stack_ofs] + gap;
                        if (sum > SIZE_MAX) begin
                            room = 1'b0;
                        end else begin
                            size_mem[stack_ofs] = SIZE_W'(sum);
                        end
                    end
                    if (room) begin
                        stack_ofs = stack_ofs - 1;
                        size_mem[stack_ofs] = it.request_size[SIZE_W-1:0];
                    end
                end
                if (room) begin
                    free_ofs          = stop;
                    res.ok            = 1'b1;
                    res.result_offset = OFS_W'(start);
                end
            end
            OP_FREE: begin
                if (iter_mode && stack_ofs < CAPACITY) begin
                    sum = size_mem[stack_ofs];
                    if (sum <= free_ofs && it.block_offset == free_ofs - sum) begin
                        free_ofs  = it.block_offset;
                        stack_ofs = stack_ofs + 1;
                        res.ok    = 1'b1;
                    end
                end
            end
            OP_MARK: begin
                if (it.block_offset <= stack_ofs) begin
                    free_ofs = it.block_offset;
                    res.ok   = 1'b1;
                end
            end
            default: begin
                if (CAPACITY - stack_ofs > it.block_index) begin
                    pos  = free_ofs;
                    room = 1'b1;
                    for (k = 0; k <= it.block_index && room; k++) begin
                        sum = size_mem[stack_ofs + k];
                        if (sum > pos) begin
                            room = 1'b0;
                        end else begin
                            pos = pos - sum;
                        end
                    end
                    if (room) begin
                        res.ok            = 1'b1;
                        res.result_offset = OFS_W'(pos);
                        res.result_size   = size_mem[stack_ofs + it.block_index];
                    end
                end
            end
        endcase
        res.block_count = OFS_W'(CAPACITY - stack_ofs);
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out want;
        t_out got;
        if (!i_rst_n) begin
            iter_mode = 1'b1;
            free_ofs  = 0;
            stack_ofs = CAPACITY;
            pending_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                if (pending_results.size() == 0) begin
                    $error("result transfer with no expected result waiting");
                    n_errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.ok !== want.ok) begin
                        $error("ok: expected %0d, actual %0d", want.ok, got.ok);
                        n_errors++;
                    end
                    if (got.result_offset !== want.result_offset) begin
                        $error("result_offset: expected %0d, actual %0d",
                               want.result_offset, got.result_offset);
                        n_errors++;
                    end
                    if (got.result_size !== want.result_size) begin
                        $error("result_size: expected %0d, actual %0d",
                               want.result_size, got.result_size);
                        n_errors++;
                    end
                    if (got.block_count !== want.block_count) begin
                        $error("block_count: expected %0d, actual %0d",
                               want.block_count, got.block_count);
                        n_errors++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                iter_mode = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                pending_results.push_back(arena_outcome(i_in_data));
            end
        end
        n_pending = pending_results.size();
    end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import saa_pkg::*;

    localparam int IDLE_LIMIT  = 20000;
    localparam int TAIL_CYCLES = 20;

    typedef enum {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_MOSTLY
    } t_rx_pattern;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    t_in  in_data   = '0;
    logic in_ready;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out out_data;
    logic cfg_valid = 1'b0;
    logic cfg_data  = 1'b0;
    logic cfg_ready;
    int   chk_errors;
    int   chk_pending;

    // Ops of items whose results are still out, plus what the last results told us.
    t_op         issued_ops [$];
    int unsigned last_count     = 0;
    int unsigned last_query_ofs = 0;
    int unsigned last_alloc_ofs = 0;
    int          items_sent     = 0;
    int          burst_left     = 0;

    t_rx_pattern rx_pattern = RX_OPEN;
    int          rx_span    = 0;
    int          rx_tick    = 0;

    always #1 clk = ~clk;

    stack_arena_allocator_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    arena_result_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .o_errors    (chk_errors),
        .o_pending   (chk_pending)
    );

    // Receiver: each stretch picks one stall pattern, from never stalling to rarely ready.
    always @(posedge clk) begin
        if (rx_span == 0) begin
            rx_pattern <= t_rx_pattern'($urandom_range(0, 3));
            rx_span    <= $urandom_range(16, 160);
        end else begin
            rx_span <= rx_span - 1;
        end
        rx_tick <= rx_tick + 1;
        case (rx_pattern)
            RX_OPEN:   out_ready <= 1'b1;
            RX_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
            RX_SPARSE: out_ready <= (rx_tick % 8 == 7);
            default:   out_ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Sampled mid-cycle, so each transfer is seen before the edge that completes it.
    always @(negedge clk) begin : track
        t_op done_op;
        if (in_valid && in_ready) begin
            issued_ops.push_back(in_data.op);
        end
        if (out_valid && out_ready && issued_ops.size() != 0) begin
            done_op    = issued_ops.pop_front();
            last_count = out_data.block_count;
            if (out_data.ok && done_op == OP_QUERY) begin
                last_query_ofs = out_data.result_offset;
            end
            if (out_data.ok && done_op == OP_ALLOC) begin
                last_alloc_ofs = out_data.result_offset;
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Simulation FAILED");
        $finish;
    end

    function automatic t_in any_item();
        t_in it;
        it.op           = t_op'($urandom_range(0, 3));
        it.request_size = OFS_W'($urandom_range(0, CAPACITY));
        it.align_log2   = ALIGN_W'($urandom_range(0, 15));
        it.block_offset = OFS_W'($urandom_range(0, CAPACITY));
        it.block_index  = IDX_W'($urandom_range(0, CAPACITY - 1));
        return it;
    endfunction

    function automatic t_in make_item(t_op op, int size, int lg, int ofs, int idx);
        t_in it;
        it.op           = op;
        it.request_size = OFS_W'(size);
        it.align_log2   = ALIGN_W'(lg);
        it.block_offset = OFS_W'(ofs);
        it.block_index  = IDX_W'(idx);
        return it;
    endfunction

    function automatic t_in alloc_item();
        t_in it;
        int  r;
        it    = any_item();
        it.op = OP_ALLOC;
        r     = $urandom_range(0, 99);
        if (r < 10) begin
            it.request_size = '0;
        end else if (r < 80) begin
            it.request_size = OFS_W'($urandom_range(1, 48));
        end else if (r < 95) begin
            it.request_size = OFS_W'($urandom_range(49, 255));
        end else begin
            it.request_size = OFS_W'($urandom_range(256, CAPACITY));
        end
        r = $urandom_range(0, 99);
        if (r < 50) begin
            it.align_log2 = ALIGN_W'($urandom_range(0, 3));
        end else if (r < 95) begin
            it.align_log2 = ALIGN_W'($urandom_range(4, 12));
        end else begin
            it.align_log2 = ALIGN_W'($urandom_range(13, 15));
        end
        return it;
    endfunction

    function automatic t_in query_item();
        t_in it;
        int  r;
        it    = any_item();
        it.op = OP_QUERY;
        r     = $urandom_range(0, 99);
        // Deep indices walk many size bytes, so most queries stay near the newest block.
        if (r < 80) begin
            it.block_index = IDX_W'($urandom_range(0, 15));
        end else if (r < 95) begin
            it.block_index = IDX_W'($urandom_range(0, 255));
        end
        return it;
    endfunction

    task automatic send(input t_in it);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                gap = $urandom_range(1, 12);
            end
        end
        burst_left--;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    // Mid-stream: hold the input until every issued item has its result back.
    task automatic wait_results();
        if (issued_ops.size() != 0) begin
            in_valid <= 1'b0;
            while (issued_ops.size() != 0) @(posedge clk);
        end
    endtask

    task automatic close_input();
        in_valid <= 1'b0;
        while (issued_ops.size() != 0) @(posedge clk);
    endtask

    task automatic set_mode(input logic mode);
        close_input();
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int quota);
        t_in it;
        int  stop_at;
        int  reps;
        int  r;
        stop_at = items_sent + quota;
        while (items_sent < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                reps = $urandom_range(1, 8);
                repeat (reps) send(alloc_item());
            end else if (r < 70) begin
                // Pop blocks LIFO: learn the newest block from a query, then free it.
                reps = $urandom_range(1, 8);
                repeat (reps) begin
                    if ($urandom_range(0, 3) == 0) begin
                        wait_results();
                        it              = any_item();
                        it.op           = OP_MARK;
                        it.block_offset = OFS_W'(CAPACITY - last_count);
                        send(it);
                    end
                    it             = any_item();
                    it.op          = OP_QUERY;
                    it.block_index = '0;
                    send(it);
                    wait_results();
                    it              = any_item();
                    it.op           = OP_FREE;
                    it.block_offset = OFS_W'(last_query_ofs);
                    send(it);
                end
            end else if (r < 82) begin
                reps = $urandom_range(1, 4);
                repeat (reps) send(query_item());
            end else if (r < 88) begin
                it    = any_item();
                it.op = OP_MARK;
                if ($urandom_range(0, 3) == 0) begin
                    it.block_offset = '0;
                end else begin
                    it.block_offset = OFS_W'(last_alloc_ofs);
                end
                send(it);
            end else begin
                send(any_item());
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, starting from an empty heap in iterable mode.
        send(make_item(OP_QUERY, 0, 0, 0, 0));
        send(make_item(OP_FREE, 0, 0, 0, 0));
        send(make_item(OP_ALLOC, 0, 0, 0, 0));
        send(make_item(OP_ALLOC, 255, 0, 0, 0));
        send(make_item(OP_ALLOC, 256, 0, 0, 0));
        // The gap of one byte would push the previous size byte past its limit.
        send(make_item(OP_ALLOC, 1, 4, 0, 0));
        send(make_item(OP_ALLOC, 1, 13, 0, 0));
        send(make_item(OP_QUERY, 0, 0, 0, 0));
        send(make_item(OP_QUERY, 0, 0, 0, 1));
        send(make_item(OP_QUERY, 0, 0, 0, 2));
        send(make_item(OP_QUERY, 0, 0, 0, 4095));
        send(make_item(OP_FREE, 0, 0, 5, 0));
        send(make_item(OP_FREE, 0, 0, 0, 0));
        send(make_item(OP_MARK, 0, 0, 4096, 0));
        send(make_item(OP_MARK, 0, 0, 100, 0));
        send(make_item(OP_ALLOC, 200, 0, 0, 0));
        send(make_item(OP_MARK, 0, 0, 50, 0));
        // The newest size byte is now larger than the free offset.
        send(make_item(OP_QUERY, 0, 0, 0, 0));
        send(make_item(OP_FREE, 0, 0, 4096, 0));
        send(make_item(OP_MARK, 0, 0, 0, 0));
        send(make_item(OP_ALLOC, 4096, 0, 0, 0));
        send(make_item(OP_ALLOC, 5, 15, 0, 0));
        set_mode(1'b0);
        send(make_item(OP_ALLOC, 4096, 12, 0, 0));
        send(make_item(OP_ALLOC, 1, 12, 0, 0));
        send(make_item(OP_FREE, 0, 0, 0, 0));
        send(make_item(OP_QUERY, 0, 0, 0, 0));
        set_mode(1'b1);

        random_phase(400);
        set_mode(1'b0);
        random_phase(250);
        set_mode(1'b1);
        random_phase(450);
        set_mode(1'b0);
        random_phase(150);
        set_mode(1'b1);
        random_phase(250);

        close_input();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (chk_pending != 0) begin
            $error("%0d expected results never arrived", chk_pending);
        end
        if (chk_errors == 0 && chk_pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/saa_pkg.sv
src/saa_size_store.sv
src/stack_arena_allocator_unit.sv
sim/arena_result_checker.sv
sim/testbench.sv
